### rtl/core/fdpm_pkg.sv
// ----------------------------------------------------------------------------
// fdpm_pkg
// shared types and constants of the 4d projection morph pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package fdpm_pkg;

  // field widths
  localparam int COORD_W   = 32;
  localparam int MORPH_W   = 17;
  localparam int SUM_W     = 64;
  localparam int QUO_W     = 32;
  localparam int CFG_IDX_W = 2;

  // lane pipeline depth (product, truncate, partial products, sum)
  localparam int LANE_LAT  = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_W    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSP_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MORPH      = 2'd2;

  // reset values
  localparam coord_t              FOCUS_W_RST = 32'sd196608;
  localparam coord_t              GAIN_RST    = 32'sd65536;
  localparam logic [MORPH_W-1:0]  MORPH_RST   = 17'd65536;

  // signed 32-bit limits
  localparam coord_t             S32_MAX = 32'sh7FFF_FFFF;
  localparam coord_t             S32_MIN = 32'sh8000_0000;
  localparam logic [QUO_W-1:0]   NEG_LIM = 32'h8000_0000;
  localparam sum_t               SAT_HI  = 64'sd2147483647;
  localparam sum_t               SAT_LO  = -64'sd2147483648;

  // pipeline control between stages
  typedef struct packed {
    logic vld;
    logic adv;
  } fdpm_ctl_t;

endpackage

`default_nettype wire

### rtl/core/fdpm_div.sv
// ----------------------------------------------------------------------------
// fdpm_div
// pipelined restoring divider producing the saturated perspective scale
// ----------------------------------------------------------------------------
`default_nettype none

module fdpm_div import fdpm_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int TAG_W     = 96
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fdpm_ctl_t        ctl,
  input  coord_t           focus_w,
  input  coord_t           gain,
  input  coord_t           w,
  input  logic [TAG_W-1:0] tag,
  output logic             vld_o,
  output coord_t           scale_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int NUM_W = COORD_W + FRAC_BITS;
  localparam int DW    = COORD_W + 1;
  localparam int DMIN  = ((1 << FRAC_BITS) + 999) / 1000;
  localparam logic [DW-1:0] DMIN_X = DW'(DMIN);

  // front stage: clamped denominator and numerator magnitude
  logic [DW-1:0]      dfull;
  logic [COORD_W-1:0] dclamp;
  logic [COORD_W-1:0] gabs;

  always_comb begin
    dfull  = {focus_w[COORD_W-1], focus_w} - {w[COORD_W-1], w};
    dclamp = ($signed(dfull) < $signed(DMIN_X)) ? DMIN_X[COORD_W-1:0]
                                                : dfull[COORD_W-1:0];
    gabs   = gain[COORD_W-1] ? (~gain + 1'b1) : gain;
  end

  logic               p0_vld_r;
  logic [COORD_W-1:0] p0_den_r;
  logic [NUM_W-1:0]   p0_num_r;
  logic               p0_neg_r;
  logic [TAG_W-1:0]   p0_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else if (ctl.adv) begin
      p0_vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      p0_den_r <= dclamp;
      p0_num_r <= {gabs, {FRAC_BITS{1'b0}}};
      p0_neg_r <= gain[COORD_W-1];
      p0_tag_r <= tag;
    end
  end

  // iteration stages, index 0 holds the overflow check
  logic               st_vld_r [0:QUO_W];
  logic [COORD_W-1:0] st_rem_r [0:QUO_W];
  logic [QUO_W-1:0]   st_low_r [0:QUO_W];
  logic [QUO_W-1:0]   st_quo_r [0:QUO_W];
  logic [COORD_W-1:0] st_den_r [0:QUO_W];
  logic               st_neg_r [0:QUO_W];
  logic               st_ovf_r [0:QUO_W];
  logic [TAG_W-1:0]   st_tag_r [0:QUO_W];

  logic [COORD_W-1:0] top_x;
  assign top_x = COORD_W'(p0_num_r[NUM_W-1:QUO_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r[0] <= 1'b0;
    end else if (ctl.adv) begin
      st_vld_r[0] <= p0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      st_rem_r[0] <= top_x;
      st_low_r[0] <= p0_num_r[QUO_W-1:0];
      st_quo_r[0] <= '0;
      st_den_r[0] <= p0_den_r;
      st_neg_r[0] <= p0_neg_r;
      st_ovf_r[0] <= (top_x >= p0_den_r);
      st_tag_r[0] <= p0_tag_r;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [COORD_W:0] trial;
    logic             take;

    assign trial = {st_rem_r[k], st_low_r[k][QUO_W-1]};
    assign take  = (trial >= {1'b0, st_den_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[k+1] <= 1'b0;
      end else if (ctl.adv) begin
        st_vld_r[k+1] <= st_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        st_rem_r[k+1] <= take ? COORD_W'(trial - {1'b0, st_den_r[k]})
                              : trial[COORD_W-1:0];
        st_low_r[k+1] <= {st_low_r[k][QUO_W-2:0], 1'b0};
        st_quo_r[k+1] <= {st_quo_r[k][QUO_W-2:0], take};
        st_den_r[k+1] <= st_den_r[k];
        st_neg_r[k+1] <= st_neg_r[k];
        st_ovf_r[k+1] <= st_ovf_r[k];
        st_tag_r[k+1] <= st_tag_r[k];
      end
    end
  end

  // sign and saturation
  logic [QUO_W-1:0] qf;
  coord_t           sat_v;

  always_comb begin
    qf = st_quo_r[QUO_W];
    if (st_neg_r[QUO_W]) begin
      if (st_ovf_r[QUO_W] || (qf > NEG_LIM)) begin
        sat_v = S32_MIN;
      end else begin
        sat_v = ~qf + 1'b1;
      end
    end else begin
      if (st_ovf_r[QUO_W] || qf[QUO_W-1]) begin
        sat_v = S32_MAX;
      end else begin
        sat_v = qf;
      end
    end
  end

  logic             vld_r;
  coord_t           scale_r;
  logic [TAG_W-1:0] tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r <= st_vld_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      scale_r <= sat_v;
      tag_r   <= st_tag_r[QUO_W];
    end
  end

  assign vld_o   = vld_r;
  assign scale_o = scale_r;
  assign tag_o   = tag_r;

endmodule

`default_nettype wire

### rtl/core/fdpm_lane.sv
// ----------------------------------------------------------------------------
// fdpm_lane
// one coordinate lane: scale product, truncation and morph blend sum
// ----------------------------------------------------------------------------
`default_nettype none

module fdpm_lane import fdpm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               adv,
  input  coord_t             scale,
  input  coord_t             coord,
  input  coord_t             flat,
  input  logic [FRAC_BITS:0] m,
  input  logic [FRAC_BITS:0] keep,
  output sum_t               sum_o
);

  localparam int   MW   = FRAC_BITS + 1;
  localparam int   LO_W = QUO_W + MW;
  localparam int   HI_W = QUO_W + MW + 1;
  localparam int   FK_W = COORD_W + MW + 1;
  localparam sum_t BIAS = SUM_W'((1 << FRAC_BITS) - 1);

  sum_t prod_c;
  assign prod_c = SUM_W'(coord) * SUM_W'(scale);

  sum_t   prod_r;
  coord_t flat1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= prod_c;
      flat1_r <= flat;
    end
  end

  // truncate toward zero by the fraction bits
  sum_t bias_c;
  sum_t rnd_c;
  always_comb begin
    bias_c = prod_r[SUM_W-1] ? BIAS : '0;
    rnd_c  = prod_r + bias_c;
  end

  sum_t   quo_r;
  coord_t flat2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      quo_r   <= rnd_c >>> FRAC_BITS;
      flat2_r <= flat1_r;
    end
  end

  // quotient split in two halves so each multiply stays narrow
  logic        [LO_W-1:0] lo_c;
  logic signed [HI_W-1:0] hi_c;
  logic signed [FK_W-1:0] fk_c;

  assign lo_c = LO_W'(quo_r[QUO_W-1:0]) * LO_W'(m);
  assign hi_c = HI_W'($signed(quo_r[SUM_W-1:QUO_W])) * HI_W'($signed({1'b0, m}));
  assign fk_c = FK_W'(flat2_r) * FK_W'($signed({1'b0, keep}));

  logic        [LO_W-1:0] lo_r;
  logic signed [HI_W-1:0] hi_r;
  logic signed [FK_W-1:0] fk_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r <= lo_c;
      hi_r <= hi_c;
      fk_r <= fk_c;
    end
  end

  // exact value fits 64 bits, so wrapping adds are fine
  sum_t sum_c;
  assign sum_c = {hi_r[QUO_W-1:0], {QUO_W{1'b0}}}
               + {{(SUM_W-LO_W){1'b0}}, lo_r}
               + {{(SUM_W-FK_W){fk_r[FK_W-1]}}, fk_r};

  sum_t sum_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_c;
    end
  end

  assign sum_o = sum_r;

endmodule

`default_nettype wire

### rtl/core/fdpm_merge.sv
// ----------------------------------------------------------------------------
// fdpm_merge
// scales the three lane sums back, saturates them and holds the output beat
// ----------------------------------------------------------------------------
`default_nettype none

module fdpm_merge import fdpm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  fdpm_ctl_t ctl,
  input  sum_t      sum_x,
  input  sum_t      sum_y,
  input  sum_t      sum_z,
  output logic      out_valid,
  output coord_t    out_x,
  output coord_t    out_y,
  output coord_t    out_z
);

  localparam sum_t BIAS = SUM_W'((1 << FRAC_BITS) - 1);

  function automatic coord_t shrink(input sum_t v);
    sum_t b;
    sum_t t;
    b = v[SUM_W-1] ? BIAS : '0;
    t = v + b;
    t = t >>> FRAC_BITS;
    if (t > SAT_HI) begin
      shrink = S32_MAX;
    end else if (t < SAT_LO) begin
      shrink = S32_MIN;
    end else begin
      shrink = t[COORD_W-1:0];
    end
  endfunction

  logic   out_valid_r;
  coord_t out_x_r;
  coord_t out_y_r;
  coord_t out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      out_valid_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      out_x_r <= shrink(sum_x);
      out_y_r <= shrink(sum_y);
      out_z_r <= shrink(sum_z);
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

endmodule

`default_nettype wire

### rtl/core/four_d_projection_morph.sv
// ----------------------------------------------------------------------------
// four_d_projection_morph
// perspective projection of a 4d point to 3d, blended with the flat point
//
// input channel: in_valid / in_stall, one beat carries in_x, in_y, in_z, in_w
// in signed fixed point with FRAC_BITS fraction bits
// result channel: out_valid / out_stall, one beat out_x, out_y, out_z per input
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data, index 0
// focus_w, 1 perspective_gain, 2 morph_factor; other indexes are dropped;
// cfg_ready is always high, write only while no beat is in flight
// pipeline: 2 front stages, 32 divider steps, 1 saturation stage, 4 lane
// stages, 1 output stage; the 32-step pipelined divider sets the depth
// throughput: one beat per cycle while out_stall does not hold the pipe
// reset: drops all beats in flight and restores the register defaults
// stall: while a result beat waits under out_stall the whole pipe holds and
// in_stall is raised; it drops the cycle the result beat is taken
// ----------------------------------------------------------------------------
`default_nettype none

module four_d_projection_morph import fdpm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  coord_t               in_x,
  input  coord_t               in_y,
  input  coord_t               in_z,
  input  coord_t               in_w,
  output logic                 out_valid,
  input  logic                 out_stall,
  output coord_t               out_x,
  output coord_t               out_y,
  output coord_t               out_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam int MW    = FRAC_BITS + 1;
  localparam int CMP_W = (MORPH_W > MW) ? MORPH_W : MW;
  localparam int TAG_W = 3 * COORD_W;
  localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1) << FRAC_BITS;
  localparam logic [MW-1:0]    ONE_M = MW'(1) << FRAC_BITS;

  // config registers
  coord_t             focus_w_r;
  coord_t             gain_r;
  logic [MORPH_W-1:0] morph_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focus_w_r <= FOCUS_W_RST;
      gain_r    <= GAIN_RST;
      morph_r   <= MORPH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FOCUS_W:    focus_w_r <= cfg_data;
        REG_PERSP_GAIN: gain_r    <= cfg_data;
        REG_MORPH:      morph_r   <= cfg_data[MORPH_W-1:0];
        default: ;
      endcase
    end
  end

  // morph weight clamped to one, and its complement for the flat point
  logic [CMP_W-1:0] morph_x;
  logic [CMP_W-1:0] morph_c;
  logic [MW-1:0]    m_nxt;
  logic [MW-1:0]    keep_nxt;
  logic [MW-1:0]    m_r;
  logic [MW-1:0]    keep_r;

  always_comb begin
    morph_x  = CMP_W'(morph_r);
    morph_c  = (morph_x > ONE_C) ? ONE_C : morph_x;
    m_nxt    = morph_c[MW-1:0];
    keep_nxt = ONE_M - m_nxt;
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    keep_r <= keep_nxt;
  end

  // one advance for the whole pipe: it holds only while a result beat waits
  logic      adv;
  fdpm_ctl_t in_ctl;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_ctl   = '{vld: in_valid, adv: adv};

  // scale divider, point coordinates ride along as a tag
  logic             div_vld;
  coord_t           div_scale;
  logic [TAG_W-1:0] div_tag;

  fdpm_div #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (TAG_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (in_ctl),
    .focus_w (focus_w_r),
    .gain    (gain_r),
    .w       (in_w),
    .tag     ({in_x, in_y, in_z}),
    .vld_o   (div_vld),
    .scale_o (div_scale),
    .tag_o   (div_tag)
  );

  coord_t dx;
  coord_t dy;
  coord_t dz;
  assign dx = div_tag[3*COORD_W-1:2*COORD_W];
  assign dy = div_tag[2*COORD_W-1:COORD_W];
  assign dz = div_tag[COORD_W-1:0];

  // lanes: x and y blend with the point itself, z blends with zero
  sum_t sum_x;
  sum_t sum_y;
  sum_t sum_z;

  fdpm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk   (clk),
    .adv   (adv),
    .scale (div_scale),
    .coord (dx),
    .flat  (dx),
    .m     (m_r),
    .keep  (keep_r),
    .sum_o (sum_x)
  );

  fdpm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk   (clk),
    .adv   (adv),
    .scale (div_scale),
    .coord (dy),
    .flat  (dy),
    .m     (m_r),
    .keep  (keep_r),
    .sum_o (sum_y)
  );

  fdpm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk   (clk),
    .adv   (adv),
    .scale (div_scale),
    .coord (dz),
    .flat  ('0),
    .m     (m_r),
    .keep  (keep_r),
    .sum_o (sum_z)
  );

  // valid bits for the lane stages
  logic [LANE_LAT-1:0] lane_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_vld_r <= '0;
    end else if (adv) begin
      lane_vld_r <= {lane_vld_r[LANE_LAT-2:0], div_vld};
    end
  end

  fdpm_ctl_t mrg_ctl;
  assign mrg_ctl = '{vld: lane_vld_r[LANE_LAT-1], adv: adv};

  fdpm_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mrg_ctl),
    .sum_x     (sum_x),
    .sum_y     (sum_y),
    .sum_z     (sum_z),
    .out_valid (out_valid),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

  // scale never takes a sign opposite to the gain
  a_scale_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (div_vld && !gain_r[COORD_W-1]) |-> !div_scale[COORD_W-1])
    else $error("scale negative for a non-negative gain");

  a_scale_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (div_vld && gain_r[COORD_W-1]) |-> (div_scale[COORD_W-1] || div_scale == '0))
    else $error("scale positive for a negative gain");

  // with no morph the z result is the flat z, which is zero
  a_flat_z: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && m_r == '0) |-> (out_z == '0))
    else $error("z not zero with morph weight zero");

endmodule

`default_nettype wire
